[design/f16cvt_pkg.sv]
// ----------------------------------------------------------------------------
// f16cvt_pkg: shared types and constants for the half/single converter
// Opcode codes, the word type and the float encoding constants.
// ----------------------------------------------------------------------------
package f16cvt_pkg;

    localparam int unsigned WordW = 32;

    typedef logic [WordW-1:0] word_t;

    localparam logic OP_H2S = 1'b0;
    localparam logic OP_S2H = 1'b1;

    localparam logic [31:0] F32_INF = 32'h7F80_0000;
    localparam logic [15:0] F16_INF = 16'h7C00;
    localparam logic [15:0] F16_QNAN = 16'h0200;

endpackage

[design/f16cvt_core.sv]
// ----------------------------------------------------------------------------
// f16cvt_core: combinational half/single conversion
// Widens a half to a single exactly or narrows a single to a half by
// truncation; NaN narrows to a quiet NaN.
// ----------------------------------------------------------------------------
module f16cvt_core
(
    input  logic                opcode,
    input  f16cvt_pkg::word_t   operand_bits,
    output f16cvt_pkg::word_t   result_bits
);
    import f16cvt_pkg::*;

    logic        h_sign;
    logic [4:0]  h_ex;
    logic [9:0]  h_man;
    logic [3:0]  lz;
    logic [10:0] h_norm;
    logic [7:0]  h_be;
    word_t       wide;

    logic        s_sign;
    logic [7:0]  s_ex;
    logic [22:0] s_man;
    logic [23:0] s_sub;
    logic [3:0]  s_sh;
    logic [15:0] narrow;

    // Widen: leading-zero count on the subnormal mantissa
    always_comb
    begin
        h_sign = operand_bits[15];
        h_ex   = operand_bits[14:10];
        h_man  = operand_bits[9:0];
        lz     = 4'd10;
        for (int i = 0; i < 10; i++)
        begin
            if (h_man[i])
            begin
                lz = 4'(9 - i);
            end
        end
        h_norm = {1'b0, h_man} << (lz + 4'd1);
        h_be   = 8'd113 - 8'(lz) - 8'd1;
        if (h_ex == 5'd0)
        begin
            if (h_man == 10'd0)
            begin
                wide = {h_sign, 31'd0};
            end
            else
            begin
                wide = {h_sign, h_be, h_norm[9:0], 13'd0};
            end
        end
        else if (h_ex == 5'h1F)
        begin
            wide = {h_sign, 31'd0} | F32_INF | {9'd0, h_man, 13'd0};
        end
        else
        begin
            wide = {h_sign, 8'(h_ex) + 8'd112, h_man, 13'd0};
        end
    end

    // Narrow: truncate, flush tiny values, saturate overflow
    always_comb
    begin
        s_sign = operand_bits[31];
        s_ex   = operand_bits[30:23];
        s_man  = operand_bits[22:0];
        s_sh   = 4'(8'd113 - s_ex);
        s_sub  = {1'b1, s_man} >> s_sh;
        if (s_ex == 8'hFF && s_man != 23'd0)
        begin
            narrow = {s_sign, 15'd0} | F16_INF | F16_QNAN | {6'd0, s_man[22:13]};
        end
        else if (s_ex < 8'd102)
        begin
            narrow = {s_sign, 15'd0};
        end
        else if (s_ex <= 8'd112)
        begin
            narrow = {s_sign, 4'd0, s_sub[23:13]};
        end
        else if (s_ex >= 8'd143)
        begin
            narrow = {s_sign, 15'd0} | F16_INF;
        end
        else
        begin
            narrow = {s_sign, 5'(s_ex - 8'd112), s_man[22:13]};
        end
    end

    assign result_bits = (opcode == OP_H2S) ? wide : {16'd0, narrow};

endmodule

[design/fp16_fp32_converter_top.sv]
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle while m_tready is high; once both registers hold items, s_tready
// follows m_tready combinationally.
// Reset: rst_n clears the valid flags only; the payload registers are not reset.
// ----------------------------------------------------------------------------
// fp16_fp32_converter_top: streaming half/single converter
// Registers each item, converts it and holds the result for the master side.
// ----------------------------------------------------------------------------
module fp16_fp32_converter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // operand_bits[31:0]
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // result_bits[31:0]
);
    import f16cvt_pkg::*;

    logic  in_vld_reg;
    logic  in_op_reg;
    word_t in_data_reg;
    logic  out_vld_reg;
    word_t out_data_reg;
    word_t conv;
    logic  in_adv;
    logic  out_adv;

    assign out_adv  = !out_vld_reg || m_tready;
    assign in_adv   = !in_vld_reg || out_adv;
    assign s_tready = in_adv;

    f16cvt_core u_core
    (
        .opcode       (in_op_reg),
        .operand_bits (in_data_reg),
        .result_bits  (conv)
    );

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_adv)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (out_adv)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (in_adv && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (out_adv && in_vld_reg)
        begin
            out_data_reg <= conv;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

[design/f16cvt_checker.sv]
// ----------------------------------------------------------------------------
// f16cvt_checker: port-level checks for the converter
// Watches the handshakes and the result timing.
// ----------------------------------------------------------------------------
module f16cvt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Accept while the output is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Stall the input only behind a stalled result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without back-pressure");

    // An item accepted while the output is empty passes the input and result registers and then shows on m_tvalid
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
        else $error("result missing");

endmodule

bind fp16_fp32_converter_top f16cvt_checker u_f16cvt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
